/* src/ppmfd_pkg.sv */
package ppmfd_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int MAX_OUT      = 8;

  localparam int SLOT_CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int SLOT_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PUB_N_W    = $clog2(MAX_OUT + 1);
  localparam int PUB_IDX_W  = $clog2(MAX_OUT);

  localparam int TS_W     = 32;
  localparam int WIDTH_W  = 16;
  localparam int PERIOD_W = 17;
  localparam int EDGE_W   = 7;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [EDGE_W-1:0]   EDGE_SAT           = 7'd100;
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH_RESET    = 16'd800;
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RESET    = 16'd2200;
  localparam logic [WIDTH_W-1:0]  SYNC_GAP_RESET     = 16'd2500;
  localparam logic [PERIOD_W-1:0] TIMER_PERIOD_RESET = 17'd10000;

  typedef enum logic [1:0] {
    REG_MIN_WIDTH    = 2'd0,
    REG_MAX_WIDTH    = 2'd1,
    REG_SYNC_GAP     = 2'd2,
    REG_TIMER_PERIOD = 2'd3
  } ppmfd_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DELTA,
    ST_CLASS,
    ST_LOAD,
    ST_SEND
  } ppmfd_state_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]  min_width;
    logic [WIDTH_W-1:0]  max_width;
    logic [WIDTH_W-1:0]  sync_gap;
    logic [PERIOD_W-1:0] timer_period;
  } ppmfd_cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic delta;
    logic classify;
    logic load_first;
    logic send_next;
  } ppmfd_cmd_t;

  typedef struct packed {
    logic publish;
    logic out_last;
  } ppmfd_status_t;

endpackage

/* src/ppmfd_if.sv */
interface ppmfd_in_if import ppmfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TS_W-1:0]    overflow_count;
  logic [WIDTH_W-1:0] timer_count;

  modport source (output valid, overflow_count, timer_count, input ready);
  modport sink (input valid, overflow_count, timer_count, output ready);
endinterface

interface ppmfd_out_if import ppmfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         channel_index;
  logic [WIDTH_W-1:0] pulse_width;
  logic               last;
  logic               full_frame;
  logic [EDGE_W-1:0]  edges_seen;

  modport source (output valid, channel_index, pulse_width, last, full_frame, edges_seen,
                  input ready);
  modport sink (input valid, channel_index, pulse_width, last, full_frame, edges_seen,
                output ready);
endinterface

/* src/ppmfd_regs.sv */
module ppmfd_regs import ppmfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ppmfd_cfg_t         cfg_o
);

  ppmfd_cfg_t cfg_q;
  ppmfd_reg_e reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ppmfd_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width    <= MIN_WIDTH_RESET;
      cfg_q.max_width    <= MAX_WIDTH_RESET;
      cfg_q.sync_gap     <= SYNC_GAP_RESET;
      cfg_q.timer_period <= TIMER_PERIOD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MIN_WIDTH:    cfg_q.min_width    <= pwdata[WIDTH_W-1:0];
        REG_MAX_WIDTH:    cfg_q.max_width    <= pwdata[WIDTH_W-1:0];
        REG_SYNC_GAP:     cfg_q.sync_gap     <= pwdata[WIDTH_W-1:0];
        REG_TIMER_PERIOD: cfg_q.timer_period <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_WIDTH:    prdata = PDATA_W'(cfg_q.min_width);
      REG_MAX_WIDTH:    prdata = PDATA_W'(cfg_q.max_width);
      REG_SYNC_GAP:     prdata = PDATA_W'(cfg_q.sync_gap);
      REG_TIMER_PERIOD: prdata = PDATA_W'(cfg_q.timer_period);
      default:          prdata = '0;
    endcase
  end

endmodule

/* src/ppmfd_ctrl.sv */
module ppmfd_ctrl import ppmfd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  input  ppmfd_status_t status_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output ppmfd_cmd_t    cmd_o
);

  ppmfd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_DELTA;
      ST_DELTA: state_d = ST_CLASS;
      ST_CLASS: state_d = status_i.publish ? ST_LOAD : ST_IDLE;
      ST_LOAD:  state_d = ST_SEND;
      ST_SEND:  if (out_ready_i && status_i.out_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_MUL:   cmd_o.mul        = 1'b1;
      ST_DELTA: cmd_o.delta      = 1'b1;
      ST_CLASS: cmd_o.classify   = 1'b1;
      ST_LOAD:  cmd_o.load_first = 1'b1;
      ST_SEND: begin
        out_valid_o     = 1'b1;
        cmd_o.send_next = out_ready_i && !status_i.out_last;
      end
      default: ;
    endcase
  end

endmodule

/* src/ppmfd_datapath.sv */
module ppmfd_datapath import ppmfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppmfd_cfg_t         cfg_i,
  input  ppmfd_cmd_t         cmd_i,
  input  logic [TS_W-1:0]    overflow_count_i,
  input  logic [WIDTH_W-1:0] timer_count_i,
  output ppmfd_status_t      status_o,
  output logic [2:0]         channel_index_o,
  output logic [WIDTH_W-1:0] pulse_width_o,
  output logic               last_o,
  output logic               full_frame_o,
  output logic [EDGE_W-1:0]  edges_seen_o
);

  localparam int PROD_W = TS_W + PERIOD_W;

  logic [TS_W-1:0]    ovf_q;
  logic [WIDTH_W-1:0] tcnt_q;
  logic [PROD_W-1:0]  prod_full;
  logic [TS_W-1:0]    prod_q;
  logic [TS_W-1:0]    ts;
  logic [TS_W-1:0]    delta_q;
  logic [TS_W-1:0]    last_ts_q;

  logic                  armed_q, armed_d;
  logic [SLOT_CNT_W-1:0] slot_cnt_q, slot_cnt_d, pub_cnt_raw;
  logic [EDGE_W-1:0]     edge_cnt_q, edge_cnt_d;
  logic [WIDTH_W-1:0]    slots_q [NUM_CHANNELS];

  logic                 in_range, is_sync, slot_we, publish, pub_full;
  logic [PUB_N_W-1:0]   pub_n_q, pub_n_d;
  logic                 pub_full_q;
  logic [PUB_IDX_W-1:0] pub_idx_q, rd_idx;

  logic               out_last_q, out_full_q;
  logic [2:0]         out_idx_q;
  logic [WIDTH_W-1:0] out_pw_q;
  logic [EDGE_W-1:0]  out_edges_q;

  // timestamp pipeline: multiply, then add count and difference
  assign prod_full = PROD_W'(cfg_i.timer_period) * PROD_W'(ovf_q);
  assign ts        = prod_q + TS_W'(tcnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ovf_q  <= overflow_count_i;
      tcnt_q <= timer_count_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[TS_W-1:0];
    end
    if (cmd_i.delta) begin
      delta_q <= ts - last_ts_q;
    end
  end

  assign in_range = (delta_q >= TS_W'(cfg_i.min_width)) && (delta_q <= TS_W'(cfg_i.max_width));
  assign is_sync  = delta_q >= TS_W'(cfg_i.sync_gap);

  // channel range test takes priority over the sync test
  always_comb begin
    armed_d     = armed_q;
    slot_cnt_d  = slot_cnt_q;
    slot_we     = 1'b0;
    publish     = 1'b0;
    pub_full    = 1'b0;
    pub_cnt_raw = slot_cnt_q;
    if (armed_q) begin
      priority if (in_range) begin
        slot_we = slot_cnt_q < SLOT_CNT_W'(NUM_CHANNELS);
        if (slot_we) begin
          slot_cnt_d = slot_cnt_q + SLOT_CNT_W'(1);
        end
        if (slot_cnt_d >= SLOT_CNT_W'(NUM_CHANNELS)) begin
          publish     = 1'b1;
          pub_full    = 1'b1;
          pub_cnt_raw = slot_cnt_d;
          armed_d     = 1'b0;
        end
      end else if (is_sync) begin
        publish    = slot_cnt_q != '0;
        armed_d    = 1'b1;
        slot_cnt_d = '0;
      end else begin
        armed_d = 1'b0;
      end
    end else if (is_sync) begin
      armed_d    = 1'b1;
      slot_cnt_d = '0;
    end
  end

  assign pub_n_d = (32'(pub_cnt_raw) > 32'(MAX_OUT)) ? PUB_N_W'(MAX_OUT)
                                                     : PUB_N_W'(pub_cnt_raw);
  assign edge_cnt_d = (edge_cnt_q < EDGE_SAT) ? edge_cnt_q + EDGE_W'(1) : edge_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ts_q  <= '0;
      armed_q    <= 1'b0;
      slot_cnt_q <= '0;
      edge_cnt_q <= '0;
      pub_n_q    <= '0;
      pub_full_q <= 1'b0;
      pub_idx_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (cmd_i.delta) begin
        last_ts_q <= ts;
      end
      if (cmd_i.classify) begin
        armed_q    <= armed_d;
        slot_cnt_q <= slot_cnt_d;
        edge_cnt_q <= edge_cnt_d;
        if (publish) begin
          pub_n_q    <= pub_n_d;
          pub_full_q <= pub_full;
        end
      end
      if (cmd_i.load_first || cmd_i.send_next) begin
        pub_idx_q  <= rd_idx;
        out_last_q <= (PUB_N_W'(rd_idx) + PUB_N_W'(1)) == pub_n_q;
      end
    end
  end

  assign rd_idx = cmd_i.load_first ? '0 : pub_idx_q + PUB_IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify && slot_we) begin
      slots_q[SLOT_IDX_W'(slot_cnt_q)] <= delta_q[WIDTH_W-1:0];
    end
    if (cmd_i.load_first || cmd_i.send_next) begin
      out_pw_q    <= slots_q[SLOT_IDX_W'(rd_idx)];
      out_idx_q   <= 3'(rd_idx);
      out_full_q  <= pub_full_q;
      out_edges_q <= edge_cnt_q;
    end
  end

  assign status_o.publish  = publish;
  assign status_o.out_last = out_last_q;

  assign channel_index_o = out_idx_q;
  assign pulse_width_o   = out_pw_q;
  assign last_o          = out_last_q;
  assign full_frame_o    = out_full_q;
  assign edges_seen_o    = out_edges_q;

endmodule

/* src/ppm_frame_decoder.sv */
// an edge that publishes nothing steps through multiply, difference and classify, then input is ready again
// a publishing edge then loads its first result and sends one result
// per cycle while the sink is ready; the next edge is accepted only after the last result
// these steps are the multiply, difference and classify states of the controller
// async active-low reset: registers to defaults, timestamp, arming, slot and edge counts cleared
module ppm_frame_decoder import ppmfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ppmfd_in_if.sink           in_ch,
  ppmfd_out_if.source        out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ppmfd_cfg_t    cfg;
  ppmfd_cmd_t    cmd;
  ppmfd_status_t status;

  ppmfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppmfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .cmd_o       (cmd)
  );

  ppmfd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .overflow_count_i (in_ch.overflow_count),
    .timer_count_i    (in_ch.timer_count),
    .status_o         (status),
    .channel_index_o  (out_ch.channel_index),
    .pulse_width_o    (out_ch.pulse_width),
    .last_o           (out_ch.last),
    .full_frame_o     (out_ch.full_frame),
    .edges_seen_o     (out_ch.edges_seen)
  );

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while results pending");

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while previous still in work");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.ready && !out_ch.last |=>
      out_ch.valid && (out_ch.channel_index == $past(out_ch.channel_index) + 3'd1))
    else $error("channel run broken");

  a_edges_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.edges_seen <= EDGE_SAT)
    else $error("edge count above saturation");

endmodule

/* dv/ppmfd_tb_pkg.sv */
`timescale 1ns / 1ps

package ppmfd_tb_pkg;
  import ppmfd_pkg::*;

  typedef struct packed {
    logic [2:0]         channel_index;
    logic [WIDTH_W-1:0] pulse_width;
    logic               last;
    logic               full_frame;
    logic [EDGE_W-1:0]  edges_seen;
  } pulse_rec_t;

  class frame_scoreboard;
    logic [WIDTH_W-1:0]  min_width;
    logic [WIDTH_W-1:0]  max_width;
    logic [WIDTH_W-1:0]  sync_gap;
    logic [PERIOD_W-1:0] timer_period;
    logic [TS_W-1:0]     last_ts;
    bit                  armed;
    int unsigned         slot_count;
    logic [WIDTH_W-1:0]  slots [NUM_CHANNELS];
    logic [EDGE_W-1:0]   edge_count;
    pulse_rec_t          expected_pulses [$];
    int                  mismatches;

    function new();
      min_width    = MIN_WIDTH_RESET;
      max_width    = MAX_WIDTH_RESET;
      sync_gap     = SYNC_GAP_RESET;
      timer_period = TIMER_PERIOD_RESET;
      last_ts      = '0;
      armed        = 1'b0;
      slot_count   = 0;
      edge_count   = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(ppmfd_reg_e r, logic [PDATA_W-1:0] value);
      case (r)
        REG_MIN_WIDTH:    min_width    = value[WIDTH_W-1:0];
        REG_MAX_WIDTH:    max_width    = value[WIDTH_W-1:0];
        REG_SYNC_GAP:     sync_gap     = value[WIDTH_W-1:0];
        REG_TIMER_PERIOD: timer_period = value[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void publish_run(bit full);
      int unsigned n;
      pulse_rec_t  p;
      n = (slot_count > MAX_OUT) ? MAX_OUT : slot_count;
      for (int unsigned k = 0; k < n; k++) begin
        p.channel_index = k[2:0];
        p.pulse_width   = slots[k];
        p.last          = (k + 1 == n);
        p.full_frame    = full;
        p.edges_seen    = edge_count;
        expected_pulses.push_back(p);
      end
    endfunction

    // one accepted edge: timestamp, interval, then frame classification
    function void note_edge(logic [TS_W-1:0] ovf, logic [WIDTH_W-1:0] tcnt);
      logic [63:0]     prod;
      logic [TS_W-1:0] stamp;
      logic [TS_W-1:0] delta;
      prod  = 64'(timer_period) * 64'(ovf);
      stamp = prod[TS_W-1:0] + TS_W'(tcnt);
      delta = stamp - last_ts;
      last_ts = stamp;
      if (edge_count < EDGE_SAT) edge_count++;
      if (armed) begin
        // channel window is tested before the sync gap
        if (delta >= min_width && delta <= max_width) begin
          if (slot_count < NUM_CHANNELS) begin
            slots[slot_count] = delta[WIDTH_W-1:0];
            slot_count++;
          end
          if (slot_count >= NUM_CHANNELS) begin
            publish_run(1'b1);
            armed = 1'b0;
          end
        end else if (delta >= sync_gap) begin
          publish_run(1'b0);
          armed      = 1'b1;
          slot_count = 0;
        end else begin
          armed = 1'b0;
        end
      end else if (delta >= sync_gap) begin
        armed      = 1'b1;
        slot_count = 0;
      end
    endfunction

    function void check_pulse(pulse_rec_t got);
      pulse_rec_t want;
      if (expected_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pulse: ch %0d width %0d last %0b full %0b edges %0d",
                   got.channel_index, got.pulse_width, got.last, got.full_frame,
                   got.edges_seen);
        return;
      end
      want = expected_pulses.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("pulse mismatch: expected ch %0d width %0d last %0b full %0b edges %0d",
                   want.channel_index, want.pulse_width, want.last, want.full_frame,
                   want.edges_seen);
          $display("                got      ch %0d width %0d last %0b full %0b edges %0d",
                   got.channel_index, got.pulse_width, got.last, got.full_frame,
                   got.edges_seen);
        end
      end
    endfunction
  endclass

endpackage

/* dv/tb_ppm_frame_decoder.sv */
`timescale 1ns / 1ps

module tb_ppm_frame_decoder;
  import ppmfd_pkg::*;
  import ppmfd_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ppmfd_in_if  in_ch ();
  ppmfd_out_if out_ch ();

  frame_scoreboard sb;
  int              edges_sent = 0;
  int              idle_mode  = 0;
  int              cycle_count = 0;

  ppm_frame_decoder u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check accepted pulses, then pick next cycle's ready
  initial begin
    pulse_rec_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.channel_index = out_ch.channel_index;
        got.pulse_width   = out_ch.pulse_width;
        got.last          = out_ch.last;
        got.full_frame    = out_ch.full_frame;
        got.edges_seen    = out_ch.edges_seen;
        sb.check_pulse(got);
      end
      out_ch.ready <= ($urandom_range(0, 99) >=
                       ((idle_mode == 2) ? 56 : (idle_mode == 3) ? 11 : 0));
    end
  end

  task automatic send_edge(logic [TS_W-1:0] ovf, logic [WIDTH_W-1:0] tcnt);
    idle_mode = (edges_sent / 37) % 4;
    edges_sent++;
    while ($urandom_range(0, 99) < ((idle_mode == 1) ? 56 : (idle_mode == 3) ? 11 : 0)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.overflow_count <= ovf;
    in_ch.timer_count    <= tcnt;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_edge(ovf, tcnt);
  endtask

  // split a wanted timestamp into overflow and count with a random count share
  task automatic send_gap(logic [TS_W-1:0] gap);
    logic [TS_W-1:0]     target;
    logic [TS_W-1:0]     share;
    logic [TS_W-1:0]     base;
    logic [TS_W-1:0]     ovf;
    logic [TS_W-1:0]     rem;
    logic [PERIOD_W-1:0] p;
    p      = sb.timer_period;
    target = sb.last_ts + gap;
    share  = $urandom_range(0, 65536 - int'(p));
    base   = target - share;
    ovf    = base / TS_W'(p);
    rem    = base - ovf * TS_W'(p);
    send_edge(ovf, WIDTH_W'(share + rem));
  endtask

  function automatic logic [TS_W-1:0] channel_gap();
    return $urandom_range(sb.min_width, sb.max_width);
  endfunction

  function automatic logic [TS_W-1:0] sync_delta();
    logic [TS_W-1:0] floor_gap;
    logic [TS_W-1:0] d;
    floor_gap = sb.sync_gap;
    if (sb.min_width <= sb.max_width && sb.max_width >= sb.sync_gap)
      floor_gap = TS_W'(sb.max_width) + 1;
    case ($urandom_range(0, 7))
      0: d = floor_gap;
      1: begin
        d = $urandom;
        if (d < floor_gap) d = floor_gap;
      end
      default: d = floor_gap + $urandom_range(0, 4000);
    endcase
    return d;
  endfunction

  // an interval that is neither a channel nor a sync gap, where one exists
  function automatic logic [TS_W-1:0] break_gap();
    int unsigned lim;
    lim = (sb.min_width < sb.sync_gap) ? sb.min_width : sb.sync_gap;
    if (lim > 0) return $urandom_range(0, lim - 1);
    if (int'(sb.max_width) + 1 < int'(sb.sync_gap))
      return $urandom_range(int'(sb.max_width) + 1, int'(sb.sync_gap) - 1);
    return $urandom;
  endfunction

  task automatic write_reg(ppmfd_reg_e r, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, value);
  endtask

  task automatic configure(int unsigned min_w, int unsigned max_w, int unsigned sync_w,
                           int unsigned period);
    write_reg(REG_MIN_WIDTH, min_w);
    write_reg(REG_MAX_WIDTH, max_w);
    write_reg(REG_SYNC_GAP, sync_w);
    write_reg(REG_TIMER_PERIOD, period);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_pulses.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic run_directed();
    int unsigned gaps[] = '{2500, 800, 2200, 1000, 1500, 1200, 2000, 900, 1700,
                            799, 3000, 1000, 1100, 1200, 5000, 2600, 2201,
                            2500, 799, 2499, 32'hFFFF_FFFF};
    send_edge('0, '0);
    send_edge('1, '1);
    foreach (gaps[i]) send_gap(gaps[i]);
  endtask

  // mostly well-formed frames with random widths, some breaks and raw noise
  task automatic run_mixed(int n_items);
    int sent;
    int n_ch;
    int roll;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        n_ch = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : NUM_CHANNELS;
        send_gap(sync_delta());
        for (int k = 0; k < n_ch; k++) send_gap(channel_gap());
        sent += n_ch + 1;
      end else if (roll < 9) begin
        send_gap(break_gap());
        sent++;
      end else begin
        send_edge($urandom, WIDTH_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni               <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.overflow_count <= '0;
    in_ch.timer_count    <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_mixed(80);

    // widest window, sync gap inside it, fastest timer
    wait_drained();
    configure(0, 16'hFFFF, 16'hFFFF, 1);
    run_mixed(50);

    // inverted window and zero sync gap: every edge rearms, runs stay empty
    wait_drained();
    configure(16'hFFFF, 0, 0, 17'h10000);
    run_mixed(20);

    // sync gap below max width, so in-window intervals stay channels
    wait_drained();
    configure(1000, 3000, 2000, 20000);
    run_mixed(50);

    wait_drained();
    begin
      int unsigned lo;
      int unsigned hi;
      lo = $urandom_range(200, 1500);
      hi = lo + $urandom_range(0, 2000);
      configure(lo, hi, hi + $urandom_range(1, 3000), $urandom_range(1, 65536));
    end
    run_mixed(40);

    // single-value window, slowest timer
    wait_drained();
    configure(500, 500, 16'hFFFF, 17'h10000);
    run_mixed(30);

    wait_drained();
    if (sb.mismatches == 0 && sb.expected_pulses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ppmfd_pkg.sv
src/ppmfd_if.sv
src/ppmfd_regs.sv
src/ppmfd_ctrl.sv
src/ppmfd_datapath.sv
src/ppm_frame_decoder.sv
dv/ppmfd_tb_pkg.sv
dv/tb_ppm_frame_decoder.sv
